[hdl/hpt_pkg.sv]
// Types and constants shared by the homography point transform, its divider and its bench.
// No dependencies.
package hpt_pkg;
	localparam int SumW = 66;
	localparam int MagW = 65;
	localparam int NumW = 84;
	localparam int DenW = 66;
	localparam int QW = 34;

	typedef enum logic [2:0] {
		REG_A_B = 3'd0,
		REG_C_D = 3'd1,
		REG_E_F = 3'd2,
		REG_G_H = 3'd3,
		REG_I = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic zero;
		logic neg_x;
		logic neg_y;
		logic eob;
	} flags_t;
endpackage

[hdl/hpt_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, for both coordinates.
// Depends on hpt_pkg.
module hpt_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [hpt_pkg::NumW-1:0]   num_x,
	input  logic [hpt_pkg::NumW-1:0]   num_y,
	input  logic [hpt_pkg::DenW-1:0]   den,
	input  hpt_pkg::flags_t            in_flags,
	output logic                       out_valid,
	output logic [hpt_pkg::QW-1:0]     q_x,
	output logic [hpt_pkg::QW-1:0]     q_y,
	output hpt_pkg::flags_t            out_flags
);
	localparam int N = hpt_pkg::QW;
	localparam int RW = hpt_pkg::DenW + 1;
	localparam int NW = hpt_pkg::NumW;

	// quotient below 2^34 is all that matters; high bits fold into an overflow sticky
	logic [RW-1:0]          rx_s1 [N+1];
	logic [RW-1:0]          ry_s1 [N+1];
	logic [NW-1:0]          nx_s1 [N+1];
	logic [NW-1:0]          ny_s1 [N+1];
	logic [N-1:0]           qx_s1 [N+1];
	logic [N-1:0]           qy_s1 [N+1];
	logic [hpt_pkg::DenW-1:0] d_s1 [N+1];
	hpt_pkg::flags_t        f_s1  [N+1];
	logic                   v_s1  [N+1];
	logic                   ox_s1 [N+1];
	logic                   oy_s1 [N+1];

	// entry: remainder preloaded with the top bits of the numerator;
	// if top part already >= den the quotient overflows 2^N
	logic [NW-N-1:0] topx, topy;
	always_comb begin
		topx = num_x[NW-1:N];
		topy = num_y[NW-1:N];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1[0] <= 1'b0;
		end else if (en) begin
			v_s1[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1[0] <= RW'(topx);
			ry_s1[0] <= RW'(topy);
			nx_s1[0] <= num_x;
			ny_s1[0] <= num_y;
			qx_s1[0] <= '0;
			qy_s1[0] <= '0;
			d_s1[0] <= den;
			f_s1[0] <= in_flags;
			ox_s1[0] <= (hpt_pkg::DenW'(topx) >= den);
			oy_s1[0] <= (hpt_pkg::DenW'(topy) >= den);
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW-1:0] rx_n, ry_n, tx, ty;
		logic          bx, by;
		always_comb begin
			tx = {rx_s1[k][RW-2:0], nx_s1[k][N-1-k]};
			ty = {ry_s1[k][RW-2:0], ny_s1[k][N-1-k]};
			bx = tx >= {1'b0, d_s1[k]};
			by = ty >= {1'b0, d_s1[k]};
			rx_n = bx ? tx - {1'b0, d_s1[k]} : tx;
			ry_n = by ? ty - {1'b0, d_s1[k]} : ty;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[k+1] <= 1'b0;
			end else if (en) begin
				v_s1[k+1] <= v_s1[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rx_s1[k+1] <= rx_n;
				ry_s1[k+1] <= ry_n;
				nx_s1[k+1] <= nx_s1[k];
				ny_s1[k+1] <= ny_s1[k];
				qx_s1[k+1] <= qx_s1[k] | (N'(bx) << (N-1-k));
				qy_s1[k+1] <= qy_s1[k] | (N'(by) << (N-1-k));
				d_s1[k+1] <= d_s1[k];
				f_s1[k+1] <= f_s1[k];
				ox_s1[k+1] <= ox_s1[k];
				oy_s1[k+1] <= oy_s1[k];
			end
		end
	end

	assign out_valid = v_s1[N];
	assign q_x = ox_s1[N] ? '1 : qx_s1[N];
	assign q_y = oy_s1[N] ? '1 : qy_s1[N];
	assign out_flags = f_s1[N];
endmodule

[hdl/homography_point_transform.sv]
// Homography point transform: 3x3 projective matrix applied to Q16.16 points.
// 40 register stages from the input to the output word; throughput one word per cycle
// while the output is taken; a held output stalls all.
// Products (s1), row sums (s2), magnitudes (s3), rounding numerator (s4), divider
// entry, 34 quotient bit stages, sign and saturation into the output register.
// arst_n clears the valid bits and loads the identity matrix. Depends on hpt_pkg, hpt_divider.
module homography_point_transform (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic        end_of_batch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic        zero_denominator,
	output logic        saturated,
	output logic        end_of_batch_out
);
	localparam int SW = hpt_pkg::SumW;
	localparam int MW = hpt_pkg::MagW;

	logic [63:0] ab_q, cd_q, ef_q, gh_q;
	logic [31:0] ci_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ab_q <= 64'd1048576;
			cd_q <= '0;
			ef_q <= 64'd1048576;
			gh_q <= '0;
			ci_q <= 32'd1048576;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hpt_pkg::REG_A_B: ab_q <= cfg_data;
				hpt_pkg::REG_C_D: cd_q <= cfg_data;
				hpt_pkg::REG_E_F: ef_q <= cfg_data;
				hpt_pkg::REG_G_H: gh_q <= cfg_data;
				hpt_pkg::REG_I:   ci_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// stall whole pipe when output holds an untaken word
	logic en;
	logic ov_q;
	assign en = !ov_q || out_ready;
	assign in_ready = en;

	logic signed [31:0] a, b, c, d, e, f, g, h, ci;
	assign a = ab_q[31:0];  assign b = ab_q[63:32];
	assign c = cd_q[31:0];  assign d = cd_q[63:32];
	assign e = ef_q[31:0];  assign f = ef_q[63:32];
	assign g = gh_q[31:0];  assign h = gh_q[63:32];
	assign ci = ci_q;

	// s1: six products
	logic signed [63:0] ax_s1, by_s1, dx_s1, ey_s1, gx_s1, hy_s1;
	logic signed [31:0] c_s1, f_s1, i_s1;
	logic v_s1, eob_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= a * point_x;  by_s1 <= b * point_y;
			dx_s1 <= d * point_x;  ey_s1 <= e * point_y;
			gx_s1 <= g * point_x;  hy_s1 <= h * point_y;
			c_s1 <= c; f_s1 <= f; i_s1 <= ci;
			eob_s1 <= end_of_batch;
		end
	end

	// s2: row sums
	logic signed [SW-1:0] sx_s2, sy_s2, sz_s2;
	logic v_s2, eob_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2 <= SW'(ax_s1) + SW'(by_s1) + (SW'(c_s1) <<< 16);
			sy_s2 <= SW'(dx_s1) + SW'(ey_s1) + (SW'(f_s1) <<< 16);
			sz_s2 <= SW'(gx_s1) + SW'(hy_s1) + (SW'(i_s1) <<< 16);
			eob_s2 <= eob_s1;
		end
	end

	// s3: magnitudes and signs
	logic [MW-1:0] mx_s3, my_s3, mz_s3;
	logic v_s3, nx_s3, ny_s3, zero_s3, eob_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s3 <= MW'(sx_s2[SW-1] ? -sx_s2 : sx_s2);
			my_s3 <= MW'(sy_s2[SW-1] ? -sy_s2 : sy_s2);
			mz_s3 <= MW'(sz_s2[SW-1] ? -sz_s2 : sz_s2);
			nx_s3 <= sx_s2[SW-1] ^ sz_s2[SW-1];
			ny_s3 <= sy_s2[SW-1] ^ sz_s2[SW-1];
			zero_s3 <= (sz_s2 == '0);
			eob_s3 <= eob_s2;
		end
	end

	// s4: rounding numerator (2^17*n + d) over 2d
	logic [hpt_pkg::NumW-1:0] numx_s4, numy_s4;
	logic [hpt_pkg::DenW-1:0] den_s4;
	hpt_pkg::flags_t fl_s4;
	logic v_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			numx_s4 <= (hpt_pkg::NumW'(mx_s3) << 17) + hpt_pkg::NumW'(mz_s3);
			numy_s4 <= (hpt_pkg::NumW'(my_s3) << 17) + hpt_pkg::NumW'(mz_s3);
			den_s4 <= zero_s3 ? hpt_pkg::DenW'(1) : {mz_s3, 1'b0};
			fl_s4 <= '{zero: zero_s3, neg_x: nx_s3, neg_y: ny_s3, eob: eob_s3};
		end
	end

	logic dv;
	logic [hpt_pkg::QW-1:0] qx, qy;
	hpt_pkg::flags_t dfl;
	hpt_divider u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.num_x(numx_s4), .num_y(numy_s4), .den(den_s4), .in_flags(fl_s4),
		.out_valid(dv), .q_x(qx), .q_y(qy), .out_flags(dfl)
	);

	logic [31:0] rx, ry;
	logic sx, sy;
	always_comb begin
		sx = dfl.neg_x ? (qx > 34'h080000000) : (qx > 34'h07FFFFFFF);
		sy = dfl.neg_y ? (qy > 34'h080000000) : (qy > 34'h07FFFFFFF);
		rx = sx ? (dfl.neg_x ? 32'h80000000 : 32'h7FFFFFFF) : 32'(dfl.neg_x ? -qx : qx);
		ry = sy ? (dfl.neg_y ? 32'h80000000 : 32'h7FFFFFFF) : 32'(dfl.neg_y ? -qy : qy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (en) ov_q <= dv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_x <= dfl.zero ? '0 : rx;
			out_y <= dfl.zero ? '0 : ry;
			zero_denominator <= dfl.zero;
			saturated <= !dfl.zero && (sx || sy);
			end_of_batch_out <= dfl.eob;
		end
	end
	assign out_valid = ov_q;
endmodule

[hdl/hpt_checker.sv]
// Port-level checker for homography_point_transform, bound to the top level.
// Depends on hpt_pkg only through the bound design.
module hpt_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic in_ready,
	input logic zero_denominator,
	input logic saturated,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y
);
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_denominator |-> out_x == 0 && out_y == 0 && !saturated)
		else $error("zero denominator word with nonzero payload");
	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
		else $error("output word changed under stall");
endmodule

bind homography_point_transform hpt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.in_ready(in_ready), .zero_denominator(zero_denominator), .saturated(saturated),
	.out_x(out_x), .out_y(out_y)
);

[verif/tb_top.sv]
// Self-checking bench for homography_point_transform: random and directed Q16.16 points
// through programmed matrices, checked against a fixed-point projection predictor.
// Depends on hpt_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_top;
	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic eob;
	} point_t;

	typedef struct {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic zd;
		logic sat;
		logic eob;
	} proj_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [63:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [31:0] point_x = 0;
	logic signed [31:0] point_y = 0;
	logic end_of_batch = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] out_x, out_y;
	logic zero_denominator, saturated, end_of_batch_out;

	homography_point_transform dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	logic signed [31:0] mat [9];
	point_t pending_points[$];
	proj_t expected_proj[$];
	int errors = 0;
	int idle_cycles = 0;
	int in_gap = 0, out_gap = 0;
	bit cfg_req = 0;
	bit cfg_done = 0;
	logic [2:0] cfg_req_idx;
	logic [63:0] cfg_req_data;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic signed [31:0] divide_q16(logic signed [127:0] num,
			logic signed [127:0] den, inout logic sat);
		logic neg;
		logic [127:0] mn, md, q;
		logic [31:0] lim;
		neg = num[127] ^ den[127];
		mn = num[127] ? -num : num;
		md = den[127] ? -den : den;
		q = ((mn << 17) + md) / (md << 1);
		lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
		if (q > {96'd0, lim}) begin
			sat = 1;
			q = {96'd0, lim};
		end
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function automatic proj_t project_point(point_t p);
		proj_t r;
		logic signed [127:0] sx, sy, sz;
		logic s;
		sx = 128'(mat[0]) * p.px + 128'(mat[1]) * p.py + (128'(mat[2]) <<< 16);
		sy = 128'(mat[3]) * p.px + 128'(mat[4]) * p.py + (128'(mat[5]) <<< 16);
		sz = 128'(mat[6]) * p.px + 128'(mat[7]) * p.py + (128'(mat[8]) <<< 16);
		s = 0;
		r.zd = (sz == 0);
		r.ox = 0;
		r.oy = 0;
		if (!r.zd) begin
			r.ox = divide_q16(sx, sz, s);
			r.oy = divide_q16(sy, sz, s);
		end
		r.sat = s;
		r.eob = p.eob;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				cfg_valid <= 0;
				cfg_done <= 1;
			end else if (cfg_req && !cfg_valid && !cfg_done) begin
				cfg_valid <= 1;
				cfg_index <= cfg_req_idx;
				cfg_data <= cfg_req_data;
			end
			if (in_valid && in_ready) begin
				expected_proj.push_back(project_point('{point_x, point_y, end_of_batch}));
				in_gap = gap_len();
			end
			if (!(in_valid && !in_ready)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 0;
				end else if (pending_points.size() > 0) begin
					point_t p;
					p = pending_points.pop_front();
					in_valid <= 1;
					point_x <= p.px;
					point_y <= p.py;
					end_of_batch <= p.eob;
				end else
					in_valid <= 0;
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
				out_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				if (expected_proj.size() == 0) begin
					report_mismatch("unexpected word", 1, 0);
				end else begin
					proj_t e;
					e = expected_proj.pop_front();
					if (out_x !== e.ox) report_mismatch("out_x", out_x, e.ox);
					if (out_y !== e.oy) report_mismatch("out_y", out_y, e.oy);
					if (zero_denominator !== e.zd)
						report_mismatch("zero_denominator", zero_denominator, e.zd);
					if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
					if (end_of_batch_out !== e.eob)
						report_mismatch("end_of_batch_out", end_of_batch_out, e.eob);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles > 5000) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic write_reg(hpt_pkg::reg_idx_t idx, logic [63:0] v);
		cfg_req_idx = idx;
		cfg_req_data = v;
		cfg_done = 0;
		cfg_req = 1;
		wait (cfg_done);
		@(posedge clk);
		cfg_req = 0;
		case (idx)
			hpt_pkg::REG_A_B: begin mat[0] = v[31:0]; mat[1] = v[63:32]; end
			hpt_pkg::REG_C_D: begin mat[2] = v[31:0]; mat[3] = v[63:32]; end
			hpt_pkg::REG_E_F: begin mat[4] = v[31:0]; mat[5] = v[63:32]; end
			hpt_pkg::REG_G_H: begin mat[6] = v[31:0]; mat[7] = v[63:32]; end
			hpt_pkg::REG_I: mat[8] = v[31:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (pending_points.size() == 0 && !in_valid && expected_proj.size() == 0);
		repeat (50) @(posedge clk);
	endtask

	task automatic load_matrix(logic [31:0] m [9]);
		write_reg(hpt_pkg::REG_A_B, {m[1], m[0]});
		write_reg(hpt_pkg::REG_C_D, {m[3], m[2]});
		write_reg(hpt_pkg::REG_E_F, {m[5], m[4]});
		write_reg(hpt_pkg::REG_G_H, {m[7], m[6]});
		write_reg(hpt_pkg::REG_I, {32'd0, m[8]});
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
		endcase
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 0;
			2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 4194304)) - 2097152);
		endcase
	endfunction

	task automatic push_random(int n);
		repeat (n) pending_points.push_back('{rand_coord(), rand_coord(), 1'($urandom)});
	endtask

	initial begin
		logic [31:0] m [9];
		mat = '{32'h0010_0000, 0, 0, 0, 32'h0010_0000, 0, 0, 0, 32'h0010_0000};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// identity after reset: extremes and batch mark
		pending_points.push_back('{32'h7fff_ffff, 32'h8000_0000, 1'b1});
		pending_points.push_back('{32'h8000_0000, 32'h7fff_ffff, 1'b0});
		pending_points.push_back('{32'h0, 32'hffff_ffff, 1'b1});
		pending_points.push_back('{32'h0001_0000, 32'h5555_aaaa, 1'b0});
		drain();
		// Z forced to zero; tiny Z for saturation; half ties
		m = '{32'h0010_0000, 0, 0, 0, 32'h0010_0000, 0, 0, 0, 0};
		load_matrix(m);
		pending_points.push_back('{32'h1234, 32'h5678, 1'b1});
		drain();
		write_reg(hpt_pkg::REG_I, 64'h1);
		pending_points.push_back('{32'h0001_0000, 32'hffff_0000, 1'b0});
		pending_points.push_back('{32'h0, 32'h0, 1'b1});
		drain();
		write_reg(hpt_pkg::REG_I, 64'hffff_ffff_0020_0000);
		pending_points.push_back('{32'h1, 32'h3, 1'b0});
		pending_points.push_back('{32'hffff_ffff, 32'hffff_fffd, 1'b1});
		drain();
		m = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
		load_matrix(m);
		pending_points.push_back('{32'h7fff_ffff, 32'h8000_0000, 1'b0});
		pending_points.push_back('{32'h8000_0000, 32'h8000_0000, 1'b1});
		pending_points.push_back('{32'h0001_0000, 32'h0001_0000, 1'b0});
		drain();
		repeat (6) begin
			foreach (m[k]) m[k] = rand_coef();
			if ($urandom_range(0, 1)) m[8] = 32'h0010_0000;
			load_matrix(m);
			push_random(90);
			drain();
		end
		wait (expected_proj.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
